// File: rtl/positional_array_list_unit_assert.svh
// Assertion macros for the positional array list unit.
// Concurrent checks collapse to nothing when SYNTHESIS is defined.
`ifndef POSITIONAL_ARRAY_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PAL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PAL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PAL_ASSERT(lbl, clk, rstn, prop, msg)
`define PAL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/pal_pkg.sv
// Shared widths, command and status codes for the positional array list unit.
// No dependencies.
package pal_pkg;

    localparam int CAPACITY_DEF = 128;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 9;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 8;

    typedef logic [CMD_W-1:0]         t_cmd;
    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic [STAT_W-1:0]        t_status;
    typedef logic [CNT_W-1:0]         t_cnt;

    localparam t_cmd CMD_INS_AT    = 3'd0;
    localparam t_cmd CMD_INS_FIRST = 3'd1;
    localparam t_cmd CMD_INS_LAST  = 3'd2;
    localparam t_cmd CMD_DELETE    = 3'd3;
    localparam t_cmd CMD_REPLACE   = 3'd4;
    localparam t_cmd CMD_CLEAR     = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_INDEX = 2'd3;

endpackage

// File: rtl/pal_cmd_if.sv
// Command channel: valid/ready handshake carrying one list command.
// Depends on pal_pkg.
interface pal_cmd_if;
    import pal_pkg::*;

    logic  valid;
    logic  ready;
    t_cmd  command;
    t_pos  position;
    t_val  value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

// File: rtl/pal_rsp_if.sv
// Response channel: valid/ready handshake carrying one command result.
// Depends on pal_pkg.
interface pal_rsp_if;
    import pal_pkg::*;

    logic     valid;
    logic     ready;
    t_status  status;
    t_val     removed_value;
    t_cnt     count;
    logic     is_empty;
    logic     is_full;

    modport source (output valid, output status, output removed_value, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input removed_value, input count,
                    input is_empty, input is_full, output ready);
endinterface

// File: rtl/pal_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/positional_array_list_unit.sv
// Positional array list unit: ordered list of signed words in a RAM plus a fill count.
// Depends on pal_pkg, pal_cmd_if, pal_rsp_if, pal_ram and the assertion header.
//
//  channel | direction | transaction
//  i_cmd   | in        | command, position, value
//  o_rsp   | out       | status, removed_value, count, is_empty, is_full
//
// Delete and insert below the end shift the entries above the position; insert at the end and replace write one entry.
// Clear, unused codes and rejected commands go straight to the final step.
// One entry moves per cycle through the RAM port.
// i_cmd.ready is high only between commands.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
// A result waiting on o_rsp holds the sequencer in its final step until taken.
module positional_array_list_unit #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pal_cmd_if.sink     i_cmd,
    pal_rsp_if.source   o_rsp
);
    import pal_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = CW + 8;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SHUP = 2'd1;
    localparam logic [1:0] S_SHDN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_at, n_at;
    logic [AW-1:0] r_wa, n_wa;
    logic          r_pend, n_pend;
    logic          r_pfirst, n_pfirst;
    logic          r_incr, n_incr;
    t_val          r_val, n_val;
    t_val          r_removed, n_removed;
    t_status       r_status, n_status;

    logic          r_ovalid, n_ovalid;
    t_status       r_ostatus, n_ostatus;
    t_val          r_oremoved, n_oremoved;
    t_cnt          r_ocount, n_ocount;
    logic          r_oempty, n_oempty;
    logic          r_ofull, n_ofull;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_val            ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    t_val            ram_rdata;

    logic            cmd_acc;
    logic            full;
    logic            pos_neg;
    logic [CMPW-1:0] pos_u;
    logic [CMPW-1:0] cnt_x;
    logic [CW-1:0]   k_dec;

    pal_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign full        = (r_count == CAP_C);
    assign pos_neg     = i_cmd.position[POS_W-1];
    assign pos_u       = {{(CMPW-8){1'b0}}, i_cmd.position[7:0]};
    assign cnt_x       = {8'b0, r_count};
    assign k_dec       = r_k - CW'(1);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_k        = r_k;
        n_at       = r_at;
        n_wa       = r_wa;
        n_pend     = r_pend;
        n_pfirst   = r_pfirst;
        n_incr     = r_incr;
        n_val      = r_val;
        n_removed  = r_removed;
        n_status   = r_status;
        n_ovalid   = r_ovalid;
        n_ostatus  = r_ostatus;
        n_oremoved = r_oremoved;
        n_ocount   = r_ocount;
        n_oempty   = r_oempty;
        n_ofull    = r_ofull;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = r_val;
        ram_re     = 1'b0;
        ram_raddr  = '0;

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    n_removed = '0;
                    n_status  = ST_OK;
                    n_val     = i_cmd.value;
                    n_pend    = 1'b0;
                    n_state   = S_DONE;
                    unique case (i_cmd.command)
                        CMD_INS_AT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (pos_neg || pos_u > cnt_x) begin
                                n_status = ST_INDEX;
                            end else begin
                                n_at    = pos_u[CW-1:0];
                                n_k     = r_count;
                                n_incr  = 1'b1;
                                n_state = S_SHUP;
                            end
                        end
                        CMD_INS_FIRST: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_at    = '0;
                                n_k     = r_count;
                                n_incr  = 1'b1;
                                n_state = S_SHUP;
                            end
                        end
                        CMD_INS_LAST: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_at    = r_count;
                                n_k     = r_count;
                                n_incr  = 1'b1;
                                n_state = S_SHUP;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (pos_neg || pos_u >= cnt_x) begin
                                n_status = ST_INDEX;
                            end else begin
                                n_at    = pos_u[CW-1:0];
                                n_k     = pos_u[CW-1:0];
                                n_state = S_SHDN;
                            end
                        end
                        CMD_REPLACE: begin
                            if (pos_neg || pos_u >= cnt_x) begin
                                n_status = ST_INDEX;
                            end else begin
                                n_at    = pos_u[CW-1:0];
                                n_k     = pos_u[CW-1:0];
                                n_incr  = 1'b0;
                                n_state = S_SHUP;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHUP: begin
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wa;
                    ram_wdata = ram_rdata;
                end
                if (r_k > r_at) begin
                    ram_re    = 1'b1;
                    ram_raddr = k_dec[AW-1:0];
                    n_wa      = r_k[AW-1:0];
                    n_pend    = 1'b1;
                    n_k       = k_dec;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_at[AW-1:0];
                    ram_wdata = r_val;
                    n_count   = r_count + CW'(r_incr);
                    n_state   = S_DONE;
                end
            end
            S_SHDN: begin
                if (r_pend) begin
                    if (r_pfirst) begin
                        n_removed = ram_rdata;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_wa;
                        ram_wdata = ram_rdata;
                    end
                end
                if (r_k < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_k[AW-1:0];
                    n_wa      = k_dec[AW-1:0];
                    n_pfirst  = (r_k == r_at);
                    n_pend    = 1'b1;
                    n_k       = r_k + CW'(1);
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid   = 1'b1;
                    n_ostatus  = r_status;
                    n_oremoved = r_removed;
                    n_ocount   = CNT_W'(r_count);
                    n_oempty   = (r_count == '0);
                    n_ofull    = (r_count == CAP_C);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_at       <= n_at;
        r_wa       <= n_wa;
        r_pfirst   <= n_pfirst;
        r_incr     <= n_incr;
        r_val      <= n_val;
        r_removed  <= n_removed;
        r_status   <= n_status;
        r_ostatus  <= n_ostatus;
        r_oremoved <= n_oremoved;
        r_ocount   <= n_ocount;
        r_oempty   <= n_oempty;
        r_ofull    <= n_ofull;
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.status        = r_ostatus;
    assign o_rsp.removed_value = r_oremoved;
    assign o_rsp.count         = r_ocount;
    assign o_rsp.is_empty      = r_oempty;
    assign o_rsp.is_full       = r_ofull;

`include "positional_array_list_unit_assert.svh"

    `PAL_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CAP_C, "fill count beyond capacity")
    `PAL_ASSERT_IMP(a_idle_no_pend, i_clk, i_rst_n, r_state == S_IDLE, !r_pend, "read pending while idle")
    `PAL_ASSERT_IMP(a_rsp_from_done, i_clk, i_rst_n, $rose(o_rsp.valid), $past(r_state) == S_DONE, "response raised outside final step")

endmodule

// File: sim/tb_top.sv
// Testbench for positional_array_list_unit: a clocked driver and monitor on the command
// and response channels, checked against an in-bench list model. Depends on pal_pkg,
// pal_cmd_if and pal_rsp_if.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int QUIET_MAX  = 4000;
    localparam int TAIL_WAIT  = CAPACITY + 16;
    localparam int N_RANDOM   = 450;
    localparam int N_DIRECTED = 25;

    localparam t_cmd CMD_RSVD6 = 3'd6;
    localparam t_cmd CMD_RSVD7 = 3'd7;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;

    typedef struct {
        t_cmd command;
        t_pos position;
        t_val value;
        bit   hold_for_drain;
    } t_list_cmd;

    typedef struct {
        t_status status;
        t_val    removed_value;
        t_cnt    count;
        logic    is_empty;
        logic    is_full;
    } t_list_rsp;

    logic i_clk;
    logic i_rst_n;

    pal_cmd_if cmd_ch ();
    pal_rsp_if rsp_ch ();

    positional_array_list_unit #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    t_list_cmd cmd_backlog[$];
    t_list_rsp awaited_rsp[$];
    t_list_cmd in_flight;

    t_val list_mem [CAPACITY];
    int   list_len;
    int   gen_len;
    int   total_items;
    int   n_sent;
    int   fail_count;
    int   quiet_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void insert_entry(int at, t_val v);
        int k;
        for (k = list_len; k > at; k--) begin
            list_mem[k] = list_mem[k-1];
        end
        list_mem[at] = v;
        list_len++;
    endfunction

    function automatic t_list_rsp apply_list_cmd(t_list_cmd c);
        t_list_rsp r;
        int        p;
        int        k;
        bit        at_cap;
        p               = int'(c.position);
        at_cap          = (list_len >= CAPACITY);
        r.status        = ST_OK;
        r.removed_value = '0;
        case (c.command)
            CMD_INS_AT: begin
                if (at_cap) r.status = ST_FULL;
                else if (p < 0 || p > list_len) r.status = ST_INDEX;
                else insert_entry(p, c.value);
            end
            CMD_INS_FIRST: begin
                if (at_cap) r.status = ST_FULL;
                else insert_entry(0, c.value);
            end
            CMD_INS_LAST: begin
                if (at_cap) r.status = ST_FULL;
                else insert_entry(list_len, c.value);
            end
            CMD_DELETE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (p < 0 || p >= list_len) begin
                    r.status = ST_INDEX;
                end else begin
                    r.removed_value = list_mem[p];
                    for (k = p; k + 1 < list_len; k++) begin
                        list_mem[k] = list_mem[k+1];
                    end
                    list_len--;
                end
            end
            CMD_REPLACE: begin
                if (p < 0 || p >= list_len) r.status = ST_INDEX;
                else list_mem[p] = c.value;
            end
            CMD_CLEAR: list_len = 0;
            default: ;
        endcase
        r.count    = t_cnt'(list_len);
        r.is_empty = (list_len == 0);
        r.is_full  = (list_len == CAPACITY);
        return r;
    endfunction

    task automatic push_cmd(t_cmd c, t_pos pos, t_val v, bit hold);
        t_list_cmd item;
        int        p;
        item.command        = c;
        item.position       = pos;
        item.value          = v;
        item.hold_for_drain = hold;
        cmd_backlog.push_back(item);
        p = int'(pos);
        case (c)
            CMD_INS_AT:    if (gen_len < CAPACITY && p >= 0 && p <= gen_len) gen_len++;
            CMD_INS_FIRST,
            CMD_INS_LAST:  if (gen_len < CAPACITY) gen_len++;
            CMD_DELETE:    if (p >= 0 && p < gen_len) gen_len--;
            CMD_CLEAR:     gen_len = 0;
            default: ;
        endcase
    endtask

    task automatic add_random_cmd(int mode, bit force_hold);
        int   roll;
        int   vroll;
        t_cmd c;
        t_pos p;
        t_val v;
        roll = $urandom_range(99, 0);
        c    = t_cmd'($urandom_range(7, 0));
        case (mode)
            MODE_GROW: begin
                if (roll < 92) c = t_cmd'($urandom_range(2, 0));
            end
            MODE_SHRINK: begin
                if (roll < 88) c = CMD_DELETE;
            end
            default: begin
                if (roll < 30) c = t_cmd'($urandom_range(2, 0));
                else if (roll < 58) c = CMD_DELETE;
                else if (roll < 88) c = CMD_REPLACE;
                else if (roll < 91) c = CMD_CLEAR;
            end
        endcase
        p = t_pos'($urandom);
        if ($urandom_range(9, 0) != 0) begin
            if (c == CMD_INS_AT) p = t_pos'($urandom_range(gen_len, 0));
            else if ((c == CMD_DELETE || c == CMD_REPLACE) && gen_len > 0)
                p = t_pos'($urandom_range(gen_len - 1, 0));
        end
        vroll = $urandom_range(99, 0);
        if (vroll < 5) v = 32'sh8000_0000;
        else if (vroll < 10) v = 32'sh7fff_ffff;
        else v = t_val'($urandom);
        push_cmd(c, p, v, force_hold || ($urandom_range(49, 0) == 0));
    endtask

    always @(posedge i_clk) begin : cmd_driver
        bit take;
        int phase;
        int idle_pct;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            take = cmd_ch.valid && cmd_ch.ready;
            if (take) begin
                awaited_rsp.push_back(apply_list_cmd(in_flight));
                n_sent++;
            end
            phase    = (n_sent * 3) / total_items;
            idle_pct = (phase == 0) ? 24 : (phase == 1) ? 70 : 0;
            if (cmd_ch.valid && !take) begin
                // hold until accepted
            end else if (cmd_backlog.size() > 0
                         && $urandom_range(99, 0) >= idle_pct
                         && (!cmd_backlog[0].hold_for_drain || awaited_rsp.size() == 0)) begin
                in_flight        = cmd_backlog.pop_front();
                cmd_ch.valid    <= 1'b1;
                cmd_ch.command  <= in_flight.command;
                cmd_ch.position <= in_flight.position;
                cmd_ch.value    <= in_flight.value;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : rsp_monitor
        t_list_rsp want;
        int        phase;
        int        idle_pct;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (awaited_rsp.size() == 0) begin
                    $error("response transaction with none outstanding");
                    fail_count++;
                end else begin
                    want = awaited_rsp.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.removed_value !== want.removed_value) begin
                        $error("removed_value: expected %0d, got %0d",
                               want.removed_value, rsp_ch.removed_value);
                        fail_count++;
                    end
                    if (rsp_ch.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
                        fail_count++;
                    end
                    if (rsp_ch.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0b, got %0b", want.is_empty,
                               rsp_ch.is_empty);
                        fail_count++;
                    end
                    if (rsp_ch.is_full !== want.is_full) begin
                        $error("is_full: expected %0b, got %0b", want.is_full, rsp_ch.is_full);
                        fail_count++;
                    end
                end
            end
            phase    = (n_sent * 3) / total_items;
            idle_pct = (phase == 0) ? 70 : (phase == 1) ? 24 : 0;
            rsp_ch.ready <= ($urandom_range(99, 0) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = CMD_INS_AT;
        cmd_ch.position = '0;
        cmd_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        list_len        = 0;
        gen_len         = 0;
        n_sent          = 0;
        fail_count      = 0;
        quiet_cycles    = 0;

        push_cmd(CMD_DELETE,    0,    0,             1'b0);
        push_cmd(CMD_REPLACE,   0,    1,             1'b0);
        push_cmd(CMD_INS_AT,    1,    2,             1'b0);
        push_cmd(CMD_INS_AT,    -1,   3,             1'b0);
        push_cmd(CMD_INS_AT,    0,    32'sh8000_0000, 1'b0);
        push_cmd(CMD_INS_FIRST, 0,    32'sh7fff_ffff, 1'b0);
        push_cmd(CMD_INS_LAST,  0,    -1,            1'b0);
        push_cmd(CMD_INS_AT,    3,    0,             1'b0);
        push_cmd(CMD_INS_AT,    1,    32'sh5555_5555, 1'b0);
        push_cmd(CMD_INS_AT,    -256, 4,             1'b0);
        push_cmd(CMD_INS_AT,    255,  5,             1'b0);
        push_cmd(CMD_REPLACE,   5,    6,             1'b0);
        push_cmd(CMD_REPLACE,   2,    32'shaaaa_aaaa, 1'b0);
        push_cmd(CMD_REPLACE,   -1,   7,             1'b0);
        push_cmd(CMD_DELETE,    5,    0,             1'b0);
        push_cmd(CMD_DELETE,    -256, 0,             1'b0);
        push_cmd(CMD_DELETE,    2,    0,             1'b0);
        push_cmd(CMD_DELETE,    0,    0,             1'b0);
        push_cmd(CMD_DELETE,    2,    0,             1'b0);
        push_cmd(CMD_RSVD6,     -1,   -1,            1'b0);
        push_cmd(CMD_RSVD7,     255,  8,             1'b0);
        push_cmd(CMD_CLEAR,     0,    0,             1'b0);
        push_cmd(CMD_DELETE,    0,    0,             1'b0);
        push_cmd(CMD_INS_LAST,  0,    9,             1'b0);
        push_cmd(CMD_CLEAR,     -256, 0,             1'b1);

        add_random_cmd(MODE_GROW, 1'b1);
        while (gen_len < CAPACITY) add_random_cmd(MODE_GROW, 1'b0);
        repeat (6) add_random_cmd(MODE_GROW, 1'b0);
        add_random_cmd(MODE_MIX, 1'b1);
        repeat (80) add_random_cmd(MODE_MIX, 1'b0);
        add_random_cmd(MODE_SHRINK, 1'b1);
        while (gen_len > 0) add_random_cmd(MODE_SHRINK, 1'b0);
        repeat (6) add_random_cmd(MODE_SHRINK, 1'b0);
        while (cmd_backlog.size() < N_DIRECTED + N_RANDOM) add_random_cmd(MODE_MIX, 1'b0);
        total_items = cmd_backlog.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (n_sent < total_items || awaited_rsp.size() != 0);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (awaited_rsp.size() != 0) begin
            $error("%0d response transactions never arrived", awaited_rsp.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
